FILE: rtl/fsp_pkg.sv
// fsp_pkg: types, codes and helper functions of the format spec parser
// used by the interfaces, the step logic, the output stage and the top level
`default_nettype none

package fsp_pkg;

  localparam int unsigned CpW   = 21;
  localparam int unsigned NumW  = 16;
  localparam int unsigned TypeW = 7;

  localparam logic [NumW-1:0] SatMax = {NumW{1'b1}};

  // result kinds
  localparam logic [1:0] KIND_LIT  = 2'd0;
  localparam logic [1:0] KIND_SPEC = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_ESC  = 3'd1;
  localparam logic [2:0] ERR_ID   = 3'd2;
  localparam logic [2:0] ERR_SYM  = 3'd3;
  localparam logic [2:0] ERR_INC  = 3'd4;

  // align and sign codes
  localparam logic [1:0] ALN_LEFT   = 2'd1;
  localparam logic [1:0] ALN_RIGHT  = 2'd2;
  localparam logic [1:0] ALN_CENTER = 2'd3;
  localparam logic [1:0] SGN_PLUS   = 2'd1;
  localparam logic [1:0] SGN_MINUS  = 2'd2;

  // option flag bits
  localparam int unsigned FL_ARGID  = 0;
  localparam int unsigned FL_ALT    = 1;
  localparam int unsigned FL_ZERO   = 2;
  localparam int unsigned FL_WIDTH  = 3;
  localparam int unsigned FL_WIND   = 4;
  localparam int unsigned FL_PREC   = 5;
  localparam int unsigned FL_LOCALE = 6;
  localparam int unsigned FL_FILL   = 7;

  // characters
  localparam logic [CpW-1:0] CH_LBRACE = 21'h7B;
  localparam logic [CpW-1:0] CH_RBRACE = 21'h7D;
  localparam logic [CpW-1:0] CH_COLON  = 21'h3A;
  localparam logic [CpW-1:0] CH_LT     = 21'h3C;
  localparam logic [CpW-1:0] CH_GT     = 21'h3E;
  localparam logic [CpW-1:0] CH_CARET  = 21'h5E;
  localparam logic [CpW-1:0] CH_PLUS   = 21'h2B;
  localparam logic [CpW-1:0] CH_MINUS  = 21'h2D;
  localparam logic [CpW-1:0] CH_HASH   = 21'h23;
  localparam logic [CpW-1:0] CH_ZERO   = 21'h30;
  localparam logic [CpW-1:0] CH_ONE    = 21'h31;
  localparam logic [CpW-1:0] CH_NINE   = 21'h39;
  localparam logic [CpW-1:0] CH_DOT    = 21'h2E;
  localparam logic [CpW-1:0] CH_BIGL   = 21'h4C;

  // option levels
  localparam logic [3:0] LVL_OPTS   = 4'd0;
  localparam logic [3:0] LVL_SIGN   = 4'd1;
  localparam logic [3:0] LVL_ALT    = 4'd2;
  localparam logic [3:0] LVL_ZERO   = 4'd3;
  localparam logic [3:0] LVL_WIDTH  = 4'd4;
  localparam logic [3:0] LVL_AFTW   = 4'd5;
  localparam logic [3:0] LVL_AFTP   = 4'd6;
  localparam logic [3:0] LVL_TYPE   = 4'd7;
  localparam logic [3:0] LVL_CLOSE  = 4'd8;

  typedef enum logic [14:0] {
    ST_NORMAL   = 15'b000000000000001,
    ST_OPEN     = 15'b000000000000010,
    ST_CLOSE_ESC= 15'b000000000000100,
    ST_ARGID    = 15'b000000000001000,
    ST_OPTS     = 15'b000000000010000,
    ST_SIGN     = 15'b000000000100000,
    ST_ALTER    = 15'b000000001000000,
    ST_ZERO     = 15'b000000010000000,
    ST_WIDTH    = 15'b000000100000000,
    ST_WDIRECT  = 15'b000001000000000,
    ST_WIND     = 15'b000010000000000,
    ST_WAITPREC = 15'b000100000000000,
    ST_PREC     = 15'b001000000000000,
    ST_TYPE     = 15'b010000000000000,
    ST_CLOSE    = 15'b100000000000000
  } fsp_state_e;

  typedef enum logic [1:0] {
    OPT_MISS   = 2'd0,
    OPT_TAKEN  = 2'd1,
    OPT_CLOSED = 2'd2
  } fsp_opt_e;

  typedef struct packed {
    fsp_state_e       st;
    logic             halted;
    logic [CpW-1:0]   fill;
    logic [1:0]       align;
    logic [1:0]       sign;
    logic [7:0]       flags;
    logic [NumW-1:0]  width;
    logic [NumW-1:0]  prec;
    logic [TypeW-1:0] typ;
  } fsp_ctx_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [CpW-1:0]   literal_char;
    logic [CpW-1:0]   fill_char;
    logic [1:0]       align_code;
    logic [1:0]       sign_code;
    logic [7:0]       option_flags;
    logic [NumW-1:0]  field_width;
    logic [NumW-1:0]  field_precision;
    logic [TypeW-1:0] type_letter;
    logic [2:0]       error_code;
  } fsp_res_t;

  typedef struct packed {
    fsp_opt_e hit;
    fsp_ctx_t ctx;
  } fsp_opt_t;

  function automatic logic is_digit(logic [CpW-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_type(logic [CpW-1:0] c);
    logic r;
    unique case (c)
      21'h73, 21'h3F, 21'h62, 21'h42, 21'h63, 21'h64, 21'h6F, 21'h78, 21'h58,
      21'h61, 21'h41, 21'h65, 21'h45, 21'h66, 21'h46, 21'h67, 21'h47: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // v * 10 + digit, saturating
  function automatic logic [NumW-1:0] acc10(logic [NumW-1:0] v, logic [CpW-1:0] c);
    logic [NumW+3:0] r;
    r = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {{NumW{1'b0}}, c[3:0]};
    return (r > {4'd0, SatMax}) ? SatMax : r[NumW-1:0];
  endfunction

  function automatic fsp_res_t mk_res(logic [1:0] kind, logic [CpW-1:0] lit,
                                      logic [2:0] err, fsp_ctx_t x);
    fsp_res_t r;
    r = '0;
    r.kind       = kind;
    r.error_code = err;
    if (kind == KIND_LIT) begin
      r.literal_char = lit;
    end
    if (kind == KIND_SPEC) begin
      r.fill_char       = x.fill;
      r.align_code      = x.align;
      r.sign_code       = x.sign;
      r.option_flags    = x.flags;
      r.field_width     = x.width;
      r.field_precision = x.prec;
      r.type_letter     = x.typ;
    end
    return r;
  endfunction

  function automatic fsp_opt_t opt_step(logic [3:0] lvl, logic [CpW-1:0] c, fsp_ctx_t x);
    fsp_opt_t o;
    o.ctx = x;
    o.hit = OPT_TAKEN;
    priority if (lvl <= LVL_OPTS && (c == CH_LT || c == CH_GT || c == CH_CARET)) begin
      o.ctx.align = (c == CH_LT) ? ALN_LEFT : (c == CH_GT) ? ALN_RIGHT : ALN_CENTER;
      o.ctx.st    = ST_SIGN;
    end else if (lvl <= LVL_SIGN && (c == CH_PLUS || c == CH_MINUS)) begin
      o.ctx.sign = (c == CH_MINUS) ? SGN_MINUS : SGN_PLUS;
      o.ctx.st   = ST_ALTER;
    end else if (lvl <= LVL_ALT && c == CH_HASH) begin
      o.ctx.flags[FL_ALT] = 1'b1;
      o.ctx.st            = ST_ZERO;
    end else if (lvl <= LVL_ZERO && c == CH_ZERO) begin
      o.ctx.flags[FL_ZERO] = 1'b1;
      o.ctx.st             = ST_WIDTH;
    end else if (lvl <= LVL_WIDTH && c >= CH_ONE && c <= CH_NINE) begin
      o.ctx.width           = {{(NumW-4){1'b0}}, c[3:0]};
      o.ctx.flags[FL_WIDTH] = 1'b1;
      o.ctx.st              = ST_WDIRECT;
    end else if (lvl <= LVL_WIDTH && c == CH_LBRACE) begin
      o.ctx.flags[FL_WIDTH] = 1'b1;
      o.ctx.flags[FL_WIND]  = 1'b1;
      o.ctx.st              = ST_WIND;
    end else if (lvl <= LVL_AFTW && c == CH_DOT) begin
      o.ctx.prec           = '0;
      o.ctx.flags[FL_PREC] = 1'b1;
      o.ctx.st             = ST_PREC;
    end else if (lvl <= LVL_AFTP && c == CH_BIGL) begin
      o.ctx.flags[FL_LOCALE] = 1'b1;
      o.ctx.st               = ST_TYPE;
    end else if (lvl <= LVL_TYPE && is_type(c)) begin
      o.ctx.typ = c[TypeW-1:0];
      o.ctx.st  = ST_CLOSE;
    end else if (c == CH_RBRACE) begin
      o.ctx.st = ST_NORMAL;
      o.hit    = OPT_CLOSED;
    end else begin
      o.hit = OPT_MISS;
    end
    return o;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/fsp_in_if.sv
// fsp_in_if: input channel of the format spec parser, one code point per request
// depends on fsp_pkg for field widths
`default_nettype none

interface fsp_in_if
  import fsp_pkg::*;
();
  logic           valid;
  logic           ready;
  logic [CpW-1:0] code_point;
  logic           end_of_text;

  modport source (output valid, output code_point, output end_of_text, input ready);
  modport sink   (input valid, input code_point, input end_of_text, output ready);
endinterface

`default_nettype wire

FILE: rtl/fsp_out_if.sv
// fsp_out_if: result channel of the format spec parser
// depends on fsp_pkg for field widths
`default_nettype none

interface fsp_out_if
  import fsp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [CpW-1:0]   literal_char;
  logic [CpW-1:0]   fill_char;
  logic [1:0]       align_code;
  logic [1:0]       sign_code;
  logic [7:0]       option_flags;
  logic [NumW-1:0]  field_width;
  logic [NumW-1:0]  field_precision;
  logic [TypeW-1:0] type_letter;
  logic [2:0]       error_code;

  modport source (output valid, output kind, output literal_char, output fill_char,
                  output align_code, output sign_code, output option_flags,
                  output field_width, output field_precision, output type_letter,
                  output error_code, input ready);
  modport sink   (input valid, input kind, input literal_char, input fill_char,
                  input align_code, input sign_code, input option_flags,
                  input field_width, input field_precision, input type_letter,
                  input error_code, output ready);
endinterface

`default_nettype wire

FILE: rtl/fsp_step.sv
// fsp_step: combinational parser step, next context and optional result
// depends on fsp_pkg
`default_nettype none

module fsp_step
  import fsp_pkg::*;
(
  input  fsp_ctx_t       ctx_i,
  input  logic [CpW-1:0] cp_i,
  input  logic           eot_i,
  input  logic           strict_i,
  output fsp_ctx_t       ctx_o,
  output logic           emit_o,
  output fsp_res_t       res_o
);

  fsp_ctx_t   a;
  fsp_opt_t   o;
  logic       use_lvl;
  logic [3:0] lvl;

  always_comb begin
    ctx_o   = ctx_i;
    emit_o  = 1'b0;
    res_o   = '0;
    a       = ctx_i;
    o       = '0;
    use_lvl = 1'b0;
    lvl     = LVL_OPTS;
    if (eot_i) begin
      ctx_o.st     = ST_NORMAL;
      ctx_o.halted = 1'b0;
      if (!ctx_i.halted && ctx_i.st != ST_NORMAL) begin
        emit_o = 1'b1;
        if (strict_i || ctx_i.st == ST_OPEN || ctx_i.st == ST_CLOSE_ESC) begin
          res_o = mk_res(KIND_ERR, '0, ERR_INC, ctx_i);
        end else begin
          res_o = mk_res(KIND_SPEC, '0, ERR_INC, ctx_i);
        end
      end
    end else if (!ctx_i.halted) begin
      unique case (ctx_i.st)
        ST_NORMAL: begin
          if (cp_i == CH_LBRACE) begin
            ctx_o.st = ST_OPEN;
          end else if (cp_i == CH_RBRACE) begin
            ctx_o.st = ST_CLOSE_ESC;
          end else begin
            emit_o = 1'b1;
            res_o  = mk_res(KIND_LIT, cp_i, ERR_NONE, ctx_i);
          end
        end
        ST_CLOSE_ESC: begin
          ctx_o.st = ST_NORMAL;
          emit_o   = 1'b1;
          if (cp_i == CH_RBRACE) begin
            res_o = mk_res(KIND_LIT, cp_i, ERR_NONE, ctx_i);
          end else if (strict_i) begin
            ctx_o.halted = 1'b1;
            res_o        = mk_res(KIND_ERR, '0, ERR_ESC, ctx_i);
          end else begin
            res_o = mk_res(KIND_LIT, cp_i, ERR_ESC, ctx_i);
          end
        end
        ST_OPEN, ST_ARGID: begin
          if (ctx_i.st == ST_OPEN && cp_i == CH_LBRACE) begin
            ctx_o.st = ST_NORMAL;
            emit_o   = 1'b1;
            res_o    = mk_res(KIND_LIT, cp_i, ERR_NONE, ctx_i);
          end else begin
            // opening a field clears the spec
            if (ctx_i.st == ST_OPEN) begin
              a       = '0;
              a.st    = ST_ARGID;
            end
            ctx_o = a;
            if (is_digit(cp_i)) begin
              ctx_o.flags[FL_ARGID] = 1'b1;
            end else if (cp_i == CH_RBRACE) begin
              ctx_o.st = ST_NORMAL;
              emit_o   = 1'b1;
              res_o    = mk_res(KIND_SPEC, '0, ERR_NONE, a);
            end else begin
              ctx_o.st = ST_OPTS;
              if (cp_i != CH_COLON) begin
                emit_o = 1'b1;
                res_o  = mk_res(KIND_ERR, '0, ERR_ID, a);
                if (strict_i) begin
                  ctx_o.halted = 1'b1;
                end else begin
                  o = opt_step(LVL_OPTS, cp_i, ctx_o);
                  if (o.hit == OPT_MISS) begin
                    ctx_o.fill           = cp_i;
                    ctx_o.flags[FL_FILL] = 1'b1;
                  end else begin
                    ctx_o = o.ctx;
                  end
                end
              end
            end
          end
        end
        ST_WIND: begin
          if (is_digit(cp_i)) begin
            ctx_o.width = acc10(ctx_i.width, cp_i);
          end else if (cp_i == CH_RBRACE) begin
            ctx_o.st = ST_WAITPREC;
          end else begin
            emit_o       = 1'b1;
            res_o        = mk_res(KIND_ERR, '0, ERR_SYM, ctx_i);
            ctx_o.halted = strict_i;
          end
        end
        ST_WDIRECT: begin
          if (is_digit(cp_i)) begin
            ctx_o.width = acc10(ctx_i.width, cp_i);
          end else begin
            use_lvl = 1'b1;
            lvl     = LVL_AFTW;
          end
        end
        ST_PREC: begin
          if (is_digit(cp_i)) begin
            ctx_o.prec = acc10(ctx_i.prec, cp_i);
          end else begin
            use_lvl = 1'b1;
            lvl     = LVL_AFTP;
          end
        end
        ST_OPTS: begin
          use_lvl = 1'b1;
          lvl     = LVL_OPTS;
        end
        ST_SIGN: begin
          use_lvl = 1'b1;
          lvl     = LVL_SIGN;
        end
        ST_ALTER: begin
          use_lvl = 1'b1;
          lvl     = LVL_ALT;
        end
        ST_ZERO: begin
          use_lvl = 1'b1;
          lvl     = LVL_ZERO;
        end
        ST_WIDTH: begin
          use_lvl = 1'b1;
          lvl     = LVL_WIDTH;
        end
        ST_WAITPREC: begin
          use_lvl = 1'b1;
          lvl     = LVL_AFTW;
        end
        ST_TYPE: begin
          use_lvl = 1'b1;
          lvl     = LVL_TYPE;
        end
        ST_CLOSE: begin
          use_lvl = 1'b1;
          lvl     = LVL_CLOSE;
        end
        default: begin
          ctx_o.st = ST_NORMAL;
        end
      endcase

      if (use_lvl) begin
        o = opt_step(lvl, cp_i, ctx_i);
        unique case (o.hit)
          OPT_CLOSED: begin
            ctx_o  = o.ctx;
            emit_o = 1'b1;
            res_o  = mk_res(KIND_SPEC, '0, ERR_NONE, o.ctx);
          end
          OPT_TAKEN: begin
            ctx_o = o.ctx;
          end
          default: begin
            if (lvl == LVL_OPTS && !ctx_i.flags[FL_FILL]) begin
              ctx_o.fill           = cp_i;
              ctx_o.flags[FL_FILL] = 1'b1;
            end else begin
              // second fill or unexpected symbol
              emit_o = 1'b1;
              res_o  = mk_res(KIND_ERR, '0, ERR_SYM, ctx_i);
              if (strict_i) begin
                ctx_o.halted = 1'b1;
              end else if (lvl == LVL_OPTS) begin
                ctx_o.fill = cp_i;
              end
            end
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fsp_out_stage.sv
// fsp_out_stage: result register driving the output channel
// depends on fsp_pkg and fsp_out_if
`default_nettype none

module fsp_out_stage
  import fsp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fsp_res_t         res_i,
  output logic             free_o,
  fsp_out_if.source        out_o
);

  logic     valid_q, valid_d;
  fsp_res_t res_q;

  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid           = valid_q;
  assign out_o.kind            = res_q.kind;
  assign out_o.literal_char    = res_q.literal_char;
  assign out_o.fill_char       = res_q.fill_char;
  assign out_o.align_code      = res_q.align_code;
  assign out_o.sign_code       = res_q.sign_code;
  assign out_o.option_flags    = res_q.option_flags;
  assign out_o.field_width     = res_q.field_width;
  assign out_o.field_precision = res_q.field_precision;
  assign out_o.type_letter     = res_q.type_letter;
  assign out_o.error_code      = res_q.error_code;

endmodule

`default_nettype wire

FILE: rtl/format_spec_parser.sv
// format_spec_parser: top level, input register, parse context and strict flag
// depends on fsp_pkg, fsp_in_if, fsp_out_if, fsp_step and fsp_out_stage
//
//   port      dir   contents
//   in_i      sink  code_point, end_of_text
//   out_o     src   kind, literal_char, spec fields, error_code
//   cfg_*     in    strict_errors write
//
// one request per cycle sustained while the result channel does not stall; a request passes
// through the input register, then through the step logic into the result register
// the parse context updates as a request leaves the input register
// reset clears the context to normal characters, strict mode off
// a stalled result holds the input register; the input still takes a request while it is empty
`default_nettype none

module format_spec_parser
  import fsp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  fsp_in_if.sink    in_i,
  fsp_out_if.source out_o,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);

  logic           in_valid_q;
  logic [CpW-1:0] cp_q;
  logic           eot_q;
  logic           strict_q;
  fsp_ctx_t       ctx_q, ctx_d;
  logic           emit;
  fsp_res_t       res;
  logic           out_free;
  logic           advance;

  assign advance    = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || out_free;

  fsp_step u_step (
    .ctx_i    (ctx_q),
    .cp_i     (cp_q),
    .eot_i    (eot_q),
    .strict_i (strict_q),
    .ctx_o    (ctx_d),
    .emit_o   (emit),
    .res_o    (res)
  );

  fsp_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (advance && emit),
    .res_i  (res),
    .free_o (out_free),
    .out_o  (out_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      strict_q   <= 1'b0;
      ctx_q      <= '{st: ST_NORMAL, default: '0};
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (cfg_we_i) begin
        strict_q <= cfg_wdata_i;
      end
      if (advance) begin
        ctx_q <= ctx_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cp_q  <= in_i.code_point;
      eot_q <= in_i.end_of_text;
    end
  end

  // a halted parser stays silent until end of text
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && ctx_q.halted && !eot_q) |-> !emit)
    else $error("output while halted");

  // end of text always returns to normal characters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && eot_q) |=> (ctx_q.st == ST_NORMAL && !ctx_q.halted))
    else $error("end of text did not reset the parse context");

  // results only ever carry the three defined kinds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.kind == KIND_LIT || out_o.kind == KIND_SPEC ||
                     out_o.kind == KIND_ERR))
    else $error("undefined result kind");

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// testbench: self-checking test of format_spec_parser with a request-level predictor
// streams literals, escaped braces, replacement fields and end-of-text markers in phases
// depends on fsp_pkg, fsp_in_if, fsp_out_if and the format_spec_parser top level

module testbench;
  import fsp_pkg::*;

  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned ITEMS_LENIENT = 50;
  localparam int unsigned ITEMS_STRICT  = 75;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned MAX_PRINTS   = 40;

  localparam logic [CpW-1:0] CH_STAR = 21'h2A;

  typedef struct {
    logic [CpW-1:0] cp;
    logic           eot;
  } char_req_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  fsp_in_if  req_ch ();
  fsp_out_if res_ch ();

  format_spec_parser i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (req_ch),
    .out_o       (res_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #1 clk = ~clk;

  char_req_t   pending_chars[$];
  fsp_res_t    expected_results[$];
  int unsigned gap_pct    = 0;
  int unsigned stall_pct  = 0;
  int unsigned n_pushed   = 0;
  int unsigned n_requests = 0;
  int unsigned n_results  = 0;
  int unsigned n_errors   = 0;
  int unsigned n_cycles   = 0;
  string       type_letters = "s?bBcdoxXaAeEfFgG";

  // predictor state
  logic             strict_on = 1'b0;
  logic             muted     = 1'b0;
  fsp_state_e       scan_state = ST_NORMAL;
  logic [CpW-1:0]   fld_fill  = '0;
  logic [1:0]       fld_align = '0;
  logic [1:0]       fld_sign  = '0;
  logic [7:0]       fld_flags = '0;
  logic [NumW-1:0]  fld_width = '0;
  logic [NumW-1:0]  fld_prec  = '0;
  logic [TypeW-1:0] fld_type  = '0;

  function automatic logic dec_char(logic [CpW-1:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic [NumW-1:0] dec_acc(logic [NumW-1:0] v, logic [CpW-1:0] c);
    int unsigned r;
    r = 32'(v) * 32'd10 + 32'(c - CH_ZERO);
    return (r > 32'd65535) ? 16'hFFFF : r[NumW-1:0];
  endfunction

  function automatic fsp_res_t build_result(logic [1:0] kind, logic [CpW-1:0] lit,
                                            logic [2:0] err);
    fsp_res_t r;
    r = '0;
    r.kind       = kind;
    r.error_code = err;
    if (kind == KIND_LIT) begin
      r.literal_char = lit;
    end
    if (kind == KIND_SPEC) begin
      r.fill_char       = fld_fill;
      r.align_code      = fld_align;
      r.sign_code       = fld_sign;
      r.option_flags    = fld_flags;
      r.field_width     = fld_width;
      r.field_precision = fld_prec;
      r.type_letter     = fld_type;
    end
    return r;
  endfunction

  function automatic fsp_res_t raise_error(logic [2:0] code);
    if (strict_on) begin
      muted = 1'b1;
    end
    return build_result(KIND_ERR, '0, code);
  endfunction

  function automatic fsp_opt_e apply_option(logic [3:0] lvl, logic [CpW-1:0] c);
    logic     type_hit;
    fsp_opt_e hit;
    type_hit = 1'b0;
    for (int i = 0; i < type_letters.len(); i++) begin
      if (c == 21'(type_letters[i])) type_hit = 1'b1;
    end
    hit = OPT_TAKEN;
    if (lvl <= LVL_OPTS && (c == CH_LT || c == CH_GT || c == CH_CARET)) begin
      fld_align  = (c == CH_LT) ? ALN_LEFT : (c == CH_GT) ? ALN_RIGHT : ALN_CENTER;
      scan_state = ST_SIGN;
    end else if (lvl <= LVL_SIGN && (c == CH_PLUS || c == CH_MINUS)) begin
      fld_sign   = (c == CH_MINUS) ? SGN_MINUS : SGN_PLUS;
      scan_state = ST_ALTER;
    end else if (lvl <= LVL_ALT && c == CH_HASH) begin
      fld_flags[FL_ALT] = 1'b1;
      scan_state        = ST_ZERO;
    end else if (lvl <= LVL_ZERO && c == CH_ZERO) begin
      fld_flags[FL_ZERO] = 1'b1;
      scan_state         = ST_WIDTH;
    end else if (lvl <= LVL_WIDTH && c >= CH_ONE && c <= CH_NINE) begin
      fld_width           = 16'(c - CH_ZERO);
      fld_flags[FL_WIDTH] = 1'b1;
      scan_state          = ST_WDIRECT;
    end else if (lvl <= LVL_WIDTH && c == CH_LBRACE) begin
      fld_flags[FL_WIDTH] = 1'b1;
      fld_flags[FL_WIND]  = 1'b1;
      scan_state          = ST_WIND;
    end else if (lvl <= LVL_AFTW && c == CH_DOT) begin
      fld_prec           = '0;
      fld_flags[FL_PREC] = 1'b1;
      scan_state         = ST_PREC;
    end else if (lvl <= LVL_AFTP && c == CH_BIGL) begin
      fld_flags[FL_LOCALE] = 1'b1;
      scan_state           = ST_TYPE;
    end else if (lvl <= LVL_TYPE && type_hit) begin
      fld_type   = c[TypeW-1:0];
      scan_state = ST_CLOSE;
    end else if (c == CH_RBRACE) begin
      scan_state = ST_NORMAL;
      hit        = OPT_CLOSED;
    end else begin
      hit = OPT_MISS;
    end
    return hit;
  endfunction

  // returns 1 when the character produces a result
  function automatic logic parse_char(input logic [CpW-1:0] c, input logic eot,
                                      output fsp_res_t res);
    fsp_state_e prev;
    logic [3:0] lvl;
    fsp_opt_e   hit;
    res = '0;
    lvl = LVL_OPTS;
    if (eot) begin
      prev       = scan_state;
      scan_state = ST_NORMAL;
      if (muted) begin
        muted = 1'b0;
        return 1'b0;
      end
      if (prev == ST_NORMAL) return 1'b0;
      if (strict_on || prev == ST_OPEN || prev == ST_CLOSE_ESC) begin
        res = build_result(KIND_ERR, '0, ERR_INC);
      end else begin
        res = build_result(KIND_SPEC, '0, ERR_INC);
      end
      return 1'b1;
    end
    if (muted) return 1'b0;
    if (scan_state == ST_NORMAL) begin
      if (c == CH_LBRACE) begin
        scan_state = ST_OPEN;
        return 1'b0;
      end
      if (c == CH_RBRACE) begin
        scan_state = ST_CLOSE_ESC;
        return 1'b0;
      end
      res = build_result(KIND_LIT, c, ERR_NONE);
      return 1'b1;
    end
    if (scan_state == ST_CLOSE_ESC) begin
      scan_state = ST_NORMAL;
      if (c == CH_RBRACE) res = build_result(KIND_LIT, c, ERR_NONE);
      else if (strict_on) res = raise_error(ERR_ESC);
      else res = build_result(KIND_LIT, c, ERR_ESC);
      return 1'b1;
    end
    if (scan_state == ST_OPEN) begin
      if (c == CH_LBRACE) begin
        scan_state = ST_NORMAL;
        res = build_result(KIND_LIT, c, ERR_NONE);
        return 1'b1;
      end
      fld_fill   = '0;
      fld_align  = '0;
      fld_sign   = '0;
      fld_flags  = '0;
      fld_width  = '0;
      fld_prec   = '0;
      fld_type   = '0;
      scan_state = ST_ARGID;
    end
    if (scan_state == ST_ARGID) begin
      if (dec_char(c)) begin
        fld_flags[FL_ARGID] = 1'b1;
        return 1'b0;
      end
      if (c == CH_RBRACE) begin
        scan_state = ST_NORMAL;
        res = build_result(KIND_SPEC, '0, ERR_NONE);
        return 1'b1;
      end
      scan_state = ST_OPTS;
      if (c == CH_COLON) return 1'b0;
      if (strict_on) begin
        res = raise_error(ERR_ID);
        return 1'b1;
      end
      if (apply_option(LVL_OPTS, c) == OPT_MISS) begin
        fld_fill           = c;
        fld_flags[FL_FILL] = 1'b1;
      end
      res = build_result(KIND_ERR, '0, ERR_ID);
      return 1'b1;
    end
    if (scan_state == ST_WIND) begin
      if (dec_char(c)) begin
        fld_width = dec_acc(fld_width, c);
        return 1'b0;
      end
      if (c == CH_RBRACE) begin
        scan_state = ST_WAITPREC;
        return 1'b0;
      end
      res = raise_error(ERR_SYM);
      return 1'b1;
    end
    case (scan_state)
      ST_WDIRECT: begin
        if (dec_char(c)) begin
          fld_width = dec_acc(fld_width, c);
          return 1'b0;
        end
        lvl = LVL_AFTW;
      end
      ST_PREC: begin
        if (dec_char(c)) begin
          fld_prec = dec_acc(fld_prec, c);
          return 1'b0;
        end
        lvl = LVL_AFTP;
      end
      ST_OPTS:     lvl = LVL_OPTS;
      ST_SIGN:     lvl = LVL_SIGN;
      ST_ALTER:    lvl = LVL_ALT;
      ST_ZERO:     lvl = LVL_ZERO;
      ST_WIDTH:    lvl = LVL_WIDTH;
      ST_WAITPREC: lvl = LVL_AFTW;
      ST_TYPE:     lvl = LVL_TYPE;
      ST_CLOSE:    lvl = LVL_CLOSE;
      default: begin
        scan_state = ST_NORMAL;
        return 1'b0;
      end
    endcase
    hit = apply_option(lvl, c);
    if (hit == OPT_CLOSED) begin
      res = build_result(KIND_SPEC, '0, ERR_NONE);
      return 1'b1;
    end
    if (hit == OPT_TAKEN) return 1'b0;
    if (lvl == LVL_OPTS) begin
      if (!fld_flags[FL_FILL]) begin
        fld_fill           = c;
        fld_flags[FL_FILL] = 1'b1;
        return 1'b0;
      end
      if (strict_on) begin
        res = raise_error(ERR_SYM);
        return 1'b1;
      end
      fld_fill = c;
      res = build_result(KIND_ERR, '0, ERR_SYM);
      return 1'b1;
    end
    res = raise_error(ERR_SYM);
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (n_errors < MAX_PRINTS) begin
      $display("mismatch on %s at result %0d: got %0h, expected %0h", what, n_results, got,
               want);
    end
    n_errors++;
  endtask

  // stimulus helpers
  function automatic logic chance(int unsigned p);
    return $urandom_range(99) < p;
  endfunction

  function automatic logic [CpW-1:0] rand_char();
    case ($urandom_range(9))
      0, 1:    return 21'($urandom_range(21'h1FFFFF));
      2:       return 21'($urandom_range(21'h10FFFF, 21'h80));
      default: return 21'($urandom_range(126, 32));
    endcase
  endfunction

  task automatic push_char(logic [CpW-1:0] cp);
    char_req_t r;
    r.cp  = cp;
    r.eot = 1'b0;
    pending_chars.push_back(r);
    n_pushed++;
  endtask

  task automatic push_eot();
    char_req_t r;
    r.cp  = 21'($urandom_range(21'h1FFFFF));
    r.eot = 1'b1;
    pending_chars.push_back(r);
    n_pushed++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(21'(s[i]));
  endtask

  task automatic push_digit();
    push_char(CH_ZERO + 21'($urandom_range(9)));
  endtask

  // one line of format text: a few segments, usually closed by end of text
  task automatic gen_line();
    int unsigned sel;
    repeat ($urandom_range(5, 1)) begin
      sel = $urandom_range(19);
      if (sel <= 5) begin
        repeat ($urandom_range(4, 1)) push_char(rand_char());
      end else if (sel == 6) begin
        push_text(chance(50) ? "{{" : "}}");
      end else if (sel == 7) begin
        push_char(CH_RBRACE);
        push_char(rand_char());
      end else if (sel == 8) begin
        push_char(chance(50) ? CH_LBRACE : CH_RBRACE);
        push_eot();
      end else begin
        push_char(CH_LBRACE);
        if (chance(35)) repeat ($urandom_range(2, 1)) push_digit();
        sel = $urandom_range(9);
        if (sel == 0) begin
          push_char(CH_RBRACE);
          continue;
        end
        // without the colon the next character is usually a bad id
        if (sel == 1) push_char(chance(50) ? rand_char() : CH_LT);
        else push_char(CH_COLON);
        if (chance(40)) push_char(chance(70) ? CH_STAR : rand_char());
        if (chance(8)) push_char(rand_char());
        if (chance(50)) begin
          case ($urandom_range(2))
            0:       push_char(CH_LT);
            1:       push_char(CH_GT);
            default: push_char(CH_CARET);
          endcase
        end
        if (chance(40)) push_char(chance(50) ? CH_PLUS : CH_MINUS);
        if (chance(30)) push_char(CH_HASH);
        if (chance(30)) push_char(CH_ZERO);
        if (chance(50)) begin
          if (chance(70)) begin
            push_char(CH_ONE + 21'($urandom_range(8)));
            repeat ($urandom_range(5)) push_digit();
          end else begin
            push_char(CH_LBRACE);
            repeat ($urandom_range(chance(15) ? 6 : 2)) push_digit();
            if (chance(8)) push_char(rand_char());
            push_char(CH_RBRACE);
          end
        end
        if (chance(40)) begin
          push_char(CH_DOT);
          repeat ($urandom_range(6)) push_digit();
        end
        if (chance(25)) push_char(CH_BIGL);
        if (chance(50)) push_char(21'(type_letters[$urandom_range(16)]));
        if (chance(8)) push_char(rand_char());
        if (chance(92)) push_char(CH_RBRACE);
      end
    end
    if (chance(75)) push_eot();
  endtask

  task automatic wait_drained();
    while (pending_chars.size() != 0 || req_ch.valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin : drive_requests
    fsp_res_t  predicted;
    char_req_t nxt;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        n_requests++;
        if (parse_char(req_ch.code_point, req_ch.end_of_text, predicted)) begin
          expected_results.push_back(predicted);
        end
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= gap_pct) begin
          nxt = pending_chars.pop_front();
          req_ch.valid       <= 1'b1;
          req_ch.code_point  <= nxt.cp;
          req_ch.end_of_text <= nxt.eot;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin : watch_results
    fsp_res_t got;
    fsp_res_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got.kind            = res_ch.kind;
      got.literal_char    = res_ch.literal_char;
      got.fill_char       = res_ch.fill_char;
      got.align_code      = res_ch.align_code;
      got.sign_code       = res_ch.sign_code;
      got.option_flags    = res_ch.option_flags;
      got.field_width     = res_ch.field_width;
      got.field_precision = res_ch.field_precision;
      got.type_letter     = res_ch.type_letter;
      got.error_code      = res_ch.error_code;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending (kind)", got.kind, '0);
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
        if (got.literal_char !== want.literal_char) begin
          report_mismatch("literal_char", got.literal_char, want.literal_char);
        end
        if (got.fill_char !== want.fill_char) begin
          report_mismatch("fill_char", got.fill_char, want.fill_char);
        end
        if (got.align_code !== want.align_code) begin
          report_mismatch("align_code", got.align_code, want.align_code);
        end
        if (got.sign_code !== want.sign_code) begin
          report_mismatch("sign_code", got.sign_code, want.sign_code);
        end
        if (got.option_flags !== want.option_flags) begin
          report_mismatch("option_flags", got.option_flags, want.option_flags);
        end
        if (got.field_width !== want.field_width) begin
          report_mismatch("field_width", got.field_width, want.field_width);
        end
        if (got.field_precision !== want.field_precision) begin
          report_mismatch("field_precision", got.field_precision, want.field_precision);
        end
        if (got.type_letter !== want.type_letter) begin
          report_mismatch("type_letter", got.type_letter, want.type_letter);
        end
        if (got.error_code !== want.error_code) begin
          report_mismatch("error_code", got.error_code, want.error_code);
        end
      end
      n_results++;
    end
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", n_cycles,
               expected_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int unsigned mode;
    int unsigned start;
    logic        strict_val;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = 1'b0;
    req_ch.valid       = 1'b0;
    req_ch.code_point  = '0;
    req_ch.end_of_text = 1'b0;
    res_ch.ready       = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      mode       = p % 4;
      strict_val = p[1] ^ p[2];
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_wdata <= strict_val;
      @(posedge clk);
      cfg_we    <= 1'b0;
      strict_on = strict_val;
      gap_pct   = (mode == 1) ? 76 : (mode == 3) ? 17 : 0;
      stall_pct = (mode == 2) ? 76 : (mode == 3) ? 17 : 0;

      if (p == 0) begin
        push_char('0);
        push_char(21'h1FFFFF);
        // escapes, lone closing brace, id-only field, every option in one field
        push_text("{{}}}a{1}{:*>+#0{3}.7Ls}");
        push_eot();
      end
      start = n_pushed;
      while (n_pushed - start < (strict_val ? ITEMS_STRICT : ITEMS_LENIENT)) gen_line();
    end
    wait_drained();

    $display("%0d requests and %0d results over %0d phases, strict mode off and on,",
             n_requests, n_results, NUM_PHASES);
    $display("with free flow, sender gaps, receiver stalls and both combined");
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/fsp_pkg.sv
rtl/fsp_in_if.sv
rtl/fsp_out_if.sv
rtl/fsp_step.sv
rtl/fsp_out_stage.sv
rtl/format_spec_parser.sv
tb/sv/testbench.sv
